// ===== design/ifhb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header builder package
// Shared types and constants for the header builder front end, queue and
// word serialiser.
// ----------------------------------------------------------------------------
package ifhb_pkg;

	localparam int unsigned IN_DATA_W  = 112;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
	localparam logic [7:0]  TTL_RESET    = 8'd64;
	localparam logic [2:0]  LAST_WORD_IX = 3'd4;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// One prepared header, waiting to be serialised.
	typedef struct packed {
		logic [15:0] total_len;
		logic [15:0] ident;
		logic [15:0] flags_off;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [19:0] csum_sum;
	} hdr_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== design/ipv4_fragment_header_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header builder
// Turns fragment descriptors into complete 20-byte IPv4 headers, checksum
// included, sent as five big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Each descriptor beat on the input stream produces five output beats, word 0
// first, with tuser carrying the word position and tlast marking word 4. The
// output stream is the bottleneck: the serialiser sends one header word per
// cycle while m_axis_tready is high, taking the next header with the last word.
// The front end registers a descriptor, stamps it with the identification
// counter and forms the checksum sum; a two-entry queue then lets it take up
// to about three further descriptors while the output is stalled. When the
// block is empty, an accepted beat passes the front-end, queue and serialiser
// registers on its way to word 0. The identification counter starts at zero,
// is placed in the header as it stands and advances by one after every
// descriptor flagged as the final fragment (tlast). The TTL register (address
// 0, reset 64) should only be written while no headers are in flight.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_builder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Descriptor stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [5:0] header_length, [21:6] payload_length, [37:22] byte_offset,
	// [45:38] protocol_number, [77:46] source_address,
	// [109:78] destination_address, [111:110] zero
	input  wire logic [111:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,   // final_fragment
	// Header word stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // [31:0] header_word
	output logic [2:0]        m_axis_tuser,   // [2:0] word_index
	output logic              m_axis_tlast,   // last_word
	// Register port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ifhb_pkg::*;

	localparam logic [2:0] ADDR_TTL = 3'd0;

	logic       ttl_wr;
	logic [7:0] ttl_val_q;
	logic       push;
	logic       pop;
	hdr_entry_t push_entry;
	hdr_entry_t head_entry;
	q_status_t  q_status;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TTL) ? {24'd0, ttl_val_q} : 32'd0;

	// Write strobe for the TTL register, high in the access phase of a write.
	assign ttl_wr = psel && penable && pwrite && (paddr == ADDR_TTL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_val_q <= TTL_RESET;
		end else if (ttl_wr) begin
			ttl_val_q <= pwdata[7:0];
		end
	end

	ifhb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_data     (s_axis_tdata),
		.s_last     (s_axis_tlast),
		.ttl        (ttl_val_q),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	ifhb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.q_status   (q_status)
	);

	ifhb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_entry (head_entry),
		.q_status   (q_status),
		.pop        (pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_user     (m_axis_tuser),
		.m_last     (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_last_on_word4: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == LAST_WORD_IX))
		else $error("tlast away from the fifth header word");
`endif

endmodule

`default_nettype wire

// ===== design/ifhb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header builder front end
// Accepts descriptors, assigns the identification and prepares the header
// fields and the raw checksum sum for the queue.
// ----------------------------------------------------------------------------
module ifhb_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_valid,
	output logic                               s_ready,
	input  wire logic [ifhb_pkg::IN_DATA_W-1:0] s_data,
	input  wire logic                          s_last,
	input  wire logic [7:0]                    ttl,
	input  wire ifhb_pkg::q_status_t           q_status,
	output logic                               push,
	output ifhb_pkg::hdr_entry_t               push_entry
);
	import ifhb_pkg::*;

	logic        valid_s1;
	logic [15:0] total_s1;
	logic [15:0] flags_s1;
	logic [15:0] ident_s1;
	logic [7:0]  ttl_s1;
	logic [7:0]  proto_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [15:0] ident_q;
	logic        accept;

	logic [5:0]  hdr_len;
	logic [15:0] pay_len;
	logic [15:0] byte_off;

	assign hdr_len  = s_data[5:0];
	assign pay_len  = s_data[21:6];
	assign byte_off = s_data[37:22];

	assign push    = valid_s1 && !q_status.full;
	assign s_ready = !valid_s1 || !q_status.full;
	assign accept  = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ident_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (accept && s_last) begin
				ident_q <= ident_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			total_s1 <= {10'd0, hdr_len} + pay_len;
			flags_s1 <= {2'b00, !s_last, byte_off[15:3]};
			ident_s1 <= ident_q;
			ttl_s1   <= ttl;
			proto_s1 <= s_data[45:38];
			src_s1   <= s_data[77:46];
			dst_s1   <= s_data[109:78];
		end
	end

	always_comb begin
		push_entry.total_len = total_s1;
		push_entry.ident     = ident_s1;
		push_entry.flags_off = flags_s1;
		push_entry.ttl       = ttl_s1;
		push_entry.proto     = proto_s1;
		push_entry.src_addr  = src_s1;
		push_entry.dst_addr  = dst_s1;
		push_entry.csum_sum  = ({4'd0, VER_IHL_TOS} + {4'd0, total_s1})
			+ ({4'd0, ident_s1} + {4'd0, flags_s1})
			+ ({4'd0, ttl_s1, proto_s1} + {4'd0, src_s1[31:16]})
			+ ({4'd0, src_s1[15:0]} + {4'd0, dst_s1[31:16]})
			+ {4'd0, dst_s1[15:0]};
	end

endmodule

`default_nettype wire

// ===== design/ifhb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header builder queue
// Short FIFO of prepared headers between the front end and the serialiser.
// ----------------------------------------------------------------------------
module ifhb_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ifhb_pkg::hdr_entry_t push_entry,
	input  wire logic                 pop,
	output ifhb_pkg::hdr_entry_t      head_entry,
	output ifhb_pkg::q_status_t       q_status
);
	import ifhb_pkg::*;

	hdr_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
		return n;
	endfunction

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_entry     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full && !pop))
		else $error("header queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty))
		else $error("header queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== design/ifhb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header builder serialiser
// Finishes the checksum and sends each header as five 32-bit words.
// ----------------------------------------------------------------------------
module ifhb_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ifhb_pkg::hdr_entry_t           head_entry,
	input  wire ifhb_pkg::q_status_t            q_status,
	output logic                                pop,
	output logic                                m_valid,
	input  wire logic                           m_ready,
	output logic [ifhb_pkg::OUT_DATA_W-1:0]     m_data,
	output logic [ifhb_pkg::OUT_USER_W-1:0]     m_user,
	output logic                                m_last
);
	import ifhb_pkg::*;

	logic        busy_q;
	logic [2:0]  idx_q;
	hdr_entry_t  ent_q;
	logic [15:0] csum_q;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic        at_last;

	assign at_last = (idx_q == LAST_WORD_IX);
	assign pop     = !q_status.empty && (!busy_q || (m_ready && at_last));

	// End-around carry folded twice, then complemented.
	assign fold1 = {1'b0, head_entry.csum_sum[15:0]} + {13'd0, head_entry.csum_sum[19:16]};
	assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && m_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= head_entry;
			csum_q <= ~fold2[15:0];
		end
	end

	always_comb begin
		case (idx_q)
			3'd0:    m_data = {VER_IHL_TOS, ent_q.total_len};
			3'd1:    m_data = {ent_q.ident, ent_q.flags_off};
			3'd2:    m_data = {ent_q.ttl, ent_q.proto, csum_q};
			3'd3:    m_data = ent_q.src_addr;
			default: m_data = ent_q.dst_addr;
		endcase
	end

	assign m_valid = busy_q;
	assign m_user  = idx_q;
	assign m_last  = at_last;

`ifndef SYNTHESIS
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= LAST_WORD_IX))
		else $error("word index out of range");
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && m_ready && !at_last) |=> (busy_q && idx_q == $past(idx_q) + 3'd1))
		else $error("header words not sent in order");
`endif

endmodule

`default_nettype wire
